>>> hw/rtl/wpse_pkg.sv
// shared constants and controller/datapath handshake types for the pair score engine
// no dependencies

package wpse_pkg;

	// default sizes of the stores
	localparam int SYMBOLS_DEF  = 32;
	localparam int MAX_LEN_DEF  = 256;
	localparam int MAX_SEQS_DEF = 64;

	// fixed field widths
	localparam int OPCODE_W = 2;
	localparam int SEQ_W    = 6;
	localparam int POS_W    = 8;
	localparam int SYM_IN_W = 5;
	localparam int VALUE_W  = 16;
	localparam int PROD_W   = 2 * VALUE_W;
	localparam int SCORE_W  = 40;
	localparam int CFG_W    = 9;

	localparam logic [CFG_W-1:0] SEQ_LEN_RESET = 9'd256;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_TABLE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WEIGHT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SYMBOL = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_SCORE  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic write;  // store write transaction accepted this cycle
		logic start;  // score transaction accepted this cycle
		logic issue;  // read one column this cycle
		logic load;   // move finished score to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;      // column reads still in flight
		logic out_free;  // output register can take a result this cycle
	} sts_t;

endpackage

>>> hw/rtl/wpse_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies

module wpse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/wpse_ctrl.sv
// controller: input handshake, length register and column walk sequencing
// depends on wpse_pkg

module wpse_ctrl import wpse_pkg::*; #(
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int MAX_SEQS = MAX_SEQS_DEF,
	localparam int CNT_W  = $clog2(MAX_LEN + 1),
	localparam int LEN_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [SEQ_W-1:0]    seq_a,
	input  logic [SEQ_W-1:0]    seq_b,
	output cmd_t                cmd,
	output logic [LEN_AW-1:0]   col,
	input  sts_t                sts
);

	localparam int LW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]       state_q;
	logic [CFG_W-1:0] seq_len_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] len_q;
	logic             accept;
	logic             pair_ok;
	logic [LW-1:0]    len_ext;
	logic [LW-1:0]    len_eff;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign pair_ok  = (int'(seq_a) < MAX_SEQS) && (int'(seq_b) < MAX_SEQS);

	// length saturates at the store depth
	assign len_ext = LW'(seq_len_q);
	assign len_eff = (len_ext > LW'(MAX_LEN)) ? LW'(MAX_LEN) : len_ext;

	assign cmd.write = accept && (opcode != OP_SCORE);
	assign cmd.start = accept && (opcode == OP_SCORE);
	assign cmd.issue = (state_q == ST_WALK);
	assign cmd.load  = (state_q == ST_DRAIN) && !sts.busy && sts.out_free;
	assign col       = col_q[LEN_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= SEQ_LEN_RESET;
		end else if (cfg_we) begin
			seq_len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			len_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						col_q <= '0;
						len_q <= len_eff[CNT_W-1:0];
						// empty walk leaves the cleared accumulator as the score
						if (pair_ok && (len_eff != '0)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_WALK: begin
					if (col_q == len_q - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (col_q < len_q))
		else $error("column counter beyond walk length");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!sts.busy && sts.out_free))
		else $error("result loaded with columns still in flight");

	a_walk_ends_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && (col_q == len_q - CNT_W'(1))) |=> (state_q == ST_DRAIN))
		else $error("walk did not finish after last column");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> in_stall)
		else $error("score transaction did not stall input");

endmodule

>>> hw/rtl/wpse_dp.sv
// datapath: table, weight and sequence stores, lookup and multiply-accumulate pipeline
// depends on wpse_pkg and wpse_ram

module wpse_dp import wpse_pkg::*; #(
	parameter int SYMBOLS  = SYMBOLS_DEF,
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int MAX_SEQS = MAX_SEQS_DEF,
	localparam int LEN_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic [LEN_AW-1:0]          col,
	output sts_t                       sts,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic [SEQ_W-1:0]           seq_a,
	input  logic [SEQ_W-1:0]           seq_b,
	input  logic [POS_W-1:0]           position,
	input  logic [SYM_IN_W-1:0]        symbol_a,
	input  logic [SYM_IN_W-1:0]        symbol_b,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SCORE_W-1:0]  score,
	output logic [SEQ_W-1:0]           pair_first,
	output logic [SEQ_W-1:0]           pair_second
);

	localparam int SYM_W     = $clog2(SYMBOLS);
	localparam int TAB_DEPTH = SYMBOLS * SYMBOLS;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int SEQ_DEPTH = MAX_SEQS * MAX_LEN;
	localparam int SEQ_AW    = $clog2(SEQ_DEPTH);

	logic                tab_we;
	logic                wgt_we;
	logic                seq_we;
	logic [TAB_AW-1:0]   tab_waddr;
	logic [TAB_AW-1:0]   tab_raddr;
	logic [VALUE_W-1:0]  tab_rdata;
	logic [LEN_AW-1:0]   wgt_waddr;
	logic [VALUE_W-1:0]  wgt_rdata;
	logic [SEQ_AW-1:0]   seq_waddr;
	logic [SYM_W-1:0]    seq_wdata;
	logic [SEQ_AW-1:0]   rd_addr_a;
	logic [SEQ_AW-1:0]   rd_addr_b;
	logic [SYM_W-1:0]    sym_a_rd;
	logic [SYM_W-1:0]    sym_b_rd;

	logic [SEQ_AW-1:0]          base_a_q;
	logic [SEQ_AW-1:0]          base_b_q;
	logic [SEQ_W-1:0]           pair_a_q;
	logic [SEQ_W-1:0]           pair_b_q;
	logic                       iss_s1;
	logic                       iss_s2;
	logic                       iss_s3;
	logic signed [VALUE_W-1:0]  wgt_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic [SCORE_W-1:0]         acc_q;
	logic                       out_valid_q;
	logic [SCORE_W-1:0]         score_q;
	logic [SEQ_W-1:0]           first_q;
	logic [SEQ_W-1:0]           second_q;

	// store writes, out-of-range targets dropped
	assign tab_we = cmd.write && (opcode == OP_TABLE)
		&& (int'(symbol_a) < SYMBOLS) && (int'(symbol_b) < SYMBOLS);
	assign wgt_we = cmd.write && (opcode == OP_WEIGHT) && (int'(position) < MAX_LEN);
	assign seq_we = cmd.write && (opcode == OP_SYMBOL) && (int'(seq_a) < MAX_SEQS)
		&& (int'(position) < MAX_LEN) && (int'(symbol_a) < SYMBOLS);

	assign tab_waddr = TAB_AW'(int'(symbol_a) * SYMBOLS + int'(symbol_b));
	assign wgt_waddr = LEN_AW'(position);
	assign seq_waddr = SEQ_AW'(int'(seq_a) * MAX_LEN + int'(position));
	assign seq_wdata = SYM_W'(symbol_a);

	assign rd_addr_a = base_a_q + SEQ_AW'(col);
	assign rd_addr_b = base_b_q + SEQ_AW'(col);
	assign tab_raddr = TAB_AW'(int'(sym_a_rd) * SYMBOLS + int'(sym_b_rd));

	wpse_ram #(.WIDTH(VALUE_W), .DEPTH(TAB_DEPTH)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (value),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	wpse_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_LEN)) u_wgt (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (value),
		.raddr (col),
		.rdata (wgt_rdata)
	);

	// two copies of the sequence store so both symbols of a column read together
	wpse_ram #(.WIDTH(SYM_W), .DEPTH(SEQ_DEPTH)) u_seq_a (
		.clk   (clk),
		.we    (seq_we),
		.waddr (seq_waddr),
		.wdata (seq_wdata),
		.raddr (rd_addr_a),
		.rdata (sym_a_rd)
	);

	wpse_ram #(.WIDTH(SYM_W), .DEPTH(SEQ_DEPTH)) u_seq_b (
		.clk   (clk),
		.we    (seq_we),
		.waddr (seq_waddr),
		.wdata (seq_wdata),
		.raddr (rd_addr_b),
		.rdata (sym_b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			iss_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			iss_s1 <= cmd.issue;
			iss_s2 <= iss_s1;
			iss_s3 <= iss_s2;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base_a_q <= SEQ_AW'(int'(seq_a) * MAX_LEN);
			base_b_q <= SEQ_AW'(int'(seq_b) * MAX_LEN);
			pair_a_q <= seq_a;
			pair_b_q <= seq_b;
		end
		wgt_s2  <= $signed(wgt_rdata);
		prod_s3 <= $signed(tab_rdata) * wgt_s2;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (iss_s3) begin
			acc_q <= acc_q + SCORE_W'(prod_s3);
		end
		if (cmd.load) begin
			score_q  <= acc_q;
			first_q  <= pair_a_q;
			second_q <= pair_b_q;
		end
	end

	assign sts.busy     = iss_s1 || iss_s2 || iss_s3;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign score       = $signed(score_q);
	assign pair_first  = first_q;
	assign pair_second = second_q;

	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write || cmd.start) |-> !(iss_s1 || iss_s2 || iss_s3))
		else $error("transaction accepted while columns in flight");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (out_valid && (score == $signed($past(acc_q)))))
		else $error("finished score not presented");

	a_no_load_over_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.load)
		else $error("pending result overwritten");

endmodule

>>> hw/rtl/weighted_pair_score_engine.sv
// top level of the weighted pair score engine
// depends on wpse_pkg, wpse_ctrl, wpse_dp (and wpse_ram through it)

// Store writes (table entry, column weight, sequence symbol) are accepted back to back.
// A score transaction walks L columns, where L is sequence_length capped at MAX_LEN;
// with no column to walk (length 0 or an out-of-range pair) the cleared accumulator is
// loaded as the result. Input stalls until the result has moved into the output register.
// The walk handles one column per cycle: the two sequence symbols and the weight are read
// in one cycle, the substitution table is read with them in the next, then one 16x16
// multiply and a 40-bit accumulate.
// A finished result waits in the output register while the next transaction is accepted;
// a following score can run, but its result is only loaded once the previous one is taken.
// The stores need no clearing after reset; entries read before they are written give no
// defined score. sequence_length resets to 256 and may only be changed while idle.

module weighted_pair_score_engine import wpse_pkg::*; #(
	parameter int SYMBOLS  = SYMBOLS_DEF,
	parameter int MAX_LEN  = MAX_LEN_DEF,
	parameter int MAX_SEQS = MAX_SEQS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [OPCODE_W-1:0]        opcode,
	input  logic [SEQ_W-1:0]           seq_a,
	input  logic [SEQ_W-1:0]           seq_b,
	input  logic [POS_W-1:0]           position,
	input  logic [SYM_IN_W-1:0]        symbol_a,
	input  logic [SYM_IN_W-1:0]        symbol_b,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SCORE_W-1:0]  score,
	output logic [SEQ_W-1:0]           pair_first,
	output logic [SEQ_W-1:0]           pair_second
);

	localparam int LEN_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	cmd_t              cmd;
	sts_t              sts;
	logic [LEN_AW-1:0] col;

	wpse_ctrl #(
		.MAX_LEN  (MAX_LEN),
		.MAX_SEQS (MAX_SEQS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.seq_a     (seq_a),
		.seq_b     (seq_b),
		.cmd       (cmd),
		.col       (col),
		.sts       (sts)
	);

	wpse_dp #(
		.SYMBOLS  (SYMBOLS),
		.MAX_LEN  (MAX_LEN),
		.MAX_SEQS (MAX_SEQS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.col         (col),
		.sts         (sts),
		.opcode      (opcode),
		.seq_a       (seq_a),
		.seq_b       (seq_b),
		.position    (position),
		.symbol_a    (symbol_a),
		.symbol_b    (symbol_b),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.score       (score),
		.pair_first  (pair_first),
		.pair_second (pair_second)
	);

endmodule

>>> tb/wpse_score_tracker_pkg.sv
// score tracker for the weighted pair score engine testbench: mirrors the stores and
// predicts each pair score. depends on wpse_pkg
`timescale 1ns / 1ps

package wpse_score_tracker_pkg;
	import wpse_pkg::*;

	typedef struct {
		logic signed [SCORE_W-1:0] score;
		logic [SEQ_W-1:0]          first;
		logic [SEQ_W-1:0]          second;
	} pair_score_t;

	class pair_score_tracker;
		logic signed [VALUE_W-1:0] subst [SYMBOLS_DEF][SYMBOLS_DEF];
		logic signed [VALUE_W-1:0] weight [MAX_LEN_DEF];
		logic [SYM_IN_W-1:0]       sym [MAX_SEQS_DEF][MAX_LEN_DEF];
		logic [CFG_W-1:0]          seq_len;
		pair_score_t               due_scores [$];
		int                        errors;
		int                        compared;

		function new();
			foreach (subst[i, j]) subst[i][j] = '0;
			foreach (weight[i]) weight[i] = '0;
			foreach (sym[i, j]) sym[i][j] = '0;
			seq_len = SEQ_LEN_RESET;
			errors = 0;
			compared = 0;
		endfunction

		function void set_length(logic [CFG_W-1:0] v);
			seq_len = v;
		endfunction

		// at the default sizes every field value addresses a real entry
		function void take_item(logic [OPCODE_W-1:0] op, logic [SEQ_W-1:0] s_a,
				logic [SEQ_W-1:0] s_b, logic [POS_W-1:0] pos, logic [SYM_IN_W-1:0] y_a,
				logic [SYM_IN_W-1:0] y_b, logic signed [VALUE_W-1:0] val);
			pair_score_t r;
			longint acc;
			int unsigned cols;
			case (op)
				OP_TABLE:  subst[y_a][y_b] = val;
				OP_WEIGHT: weight[pos] = val;
				OP_SYMBOL: sym[s_a][pos] = y_a;
				OP_SCORE: begin
					acc = 0;
					// lengths above the store size saturate
					cols = (seq_len > MAX_LEN_DEF) ? MAX_LEN_DEF : seq_len;
					for (int k = 0; k < cols; k++)
						acc += longint'(subst[sym[s_a][k]][sym[s_b][k]]) * longint'(weight[k]);
					r.score = acc[SCORE_W-1:0];
					r.first = s_a;
					r.second = s_b;
					due_scores.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_score(logic signed [SCORE_W-1:0] score, logic [SEQ_W-1:0] first,
				logic [SEQ_W-1:0] second);
			pair_score_t e;
			compared++;
			if (due_scores.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected score %0d for pair %0d/%0d", score, first, second);
				return;
			end
			e = due_scores.pop_front();
			if (e.score !== score || e.first !== first || e.second !== second) begin
				errors++;
				if (errors <= 10)
					$display("score mismatch: expected %0d for %0d/%0d, got %0d for %0d/%0d",
						e.score, e.first, e.second, score, first, second);
			end
		endfunction
	endclass

endpackage

>>> tb/tb.sv
// top of the weighted pair score engine testbench: drives store writes and score requests
// under several idling patterns. depends on wpse_pkg, wpse_score_tracker_pkg and the rtl
`timescale 1ns / 1ps

module tb;
	import wpse_pkg::*;
	import wpse_score_tracker_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_W-1:0]          cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [OPCODE_W-1:0]       opcode = OP_TABLE;
	logic [SEQ_W-1:0]          seq_a = '0;
	logic [SEQ_W-1:0]          seq_b = '0;
	logic [POS_W-1:0]          position = '0;
	logic [SYM_IN_W-1:0]       symbol_a = '0;
	logic [SYM_IN_W-1:0]       symbol_b = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [SCORE_W-1:0] score;
	logic [SEQ_W-1:0]          pair_first;
	logic [SEQ_W-1:0]          pair_second;

	weighted_pair_score_engine dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .seq_a(seq_a),
		.seq_b(seq_b), .position(position), .symbol_a(symbol_a), .symbol_b(symbol_b),
		.value(value), .out_valid(out_valid), .out_stall(out_stall), .score(score),
		.pair_first(pair_first), .pair_second(pair_second)
	);

	pair_score_tracker tracker;

	// which entries hold a defined value, so that no score ever reads an unwritten one
	bit tab_ok [SYMBOLS_DEF][SYMBOLS_DEF];
	bit wt_ok [MAX_LEN_DEF];
	bit sym_ok [MAX_SEQS_DEF][MAX_LEN_DEF];

	int               items = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int unsigned      cur_len = SEQ_LEN_RESET;
	int               fill_sym_max = 31;
	logic [SEQ_W-1:0] seq_pool [4];

	int phase_len [8]  = '{1, 8, 3, 16, 0, 5, 256, 511};
	int phase_mode [8] = '{1, 2, 3, 0, 1, 2, 3, 1};

	always #2 clk = ~clk;

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			tracker.check_score(score, pair_first, pair_second);

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send(logic [OPCODE_W-1:0] op, logic [SEQ_W-1:0] s_a,
			logic [SEQ_W-1:0] s_b, logic [POS_W-1:0] pos, logic [SYM_IN_W-1:0] y_a,
			logic [SYM_IN_W-1:0] y_b, logic signed [VALUE_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seq_a <= s_a;
		seq_b <= s_b;
		position <= pos;
		symbol_a <= y_a;
		symbol_b <= y_b;
		value <= val;
		do @(posedge clk); while (in_stall);
		tracker.take_item(op, s_a, s_b, pos, y_a, y_b, val);
		case (op)
			OP_TABLE:  tab_ok[y_a][y_b] = 1'b1;
			OP_WEIGHT: wt_ok[pos] = 1'b1;
			OP_SYMBOL: sym_ok[s_a][pos] = 1'b1;
			default: ;
		endcase
		items++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due_scores.size() != 0)
			@(negedge clk);
		// a store write may still be landing
		repeat (8) @(negedge clk);
	endtask

	task automatic set_length(logic [CFG_W-1:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_length(v);
		cur_len = v;
	endtask

	task automatic set_mode(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
			default: begin send_idle_pct = 12; recv_stall_pct = 12; end
		endcase
	endtask

	task automatic noise_write();
		logic [OPCODE_W-1:0] op;
		op = OPCODE_W'($urandom_range(OP_SYMBOL, OP_TABLE));
		send(op, SEQ_W'($urandom), SEQ_W'($urandom), POS_W'($urandom),
			SYM_IN_W'($urandom), SYM_IN_W'($urandom), VALUE_W'($urandom));
	endtask

	// writes whatever the pair still lacks over the active columns, then asks for the score
	task automatic score_pair(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		int unsigned cols;
		logic [SYM_IN_W-1:0] xa, xb;
		cols = (cur_len > MAX_LEN_DEF) ? MAX_LEN_DEF : cur_len;
		for (int k = 0; k < cols; k++) begin
			if (!wt_ok[k])
				send(OP_WEIGHT, SEQ_W'($urandom), SEQ_W'($urandom), POS_W'(k),
					SYM_IN_W'($urandom), SYM_IN_W'($urandom), VALUE_W'($urandom));
			if (!sym_ok[a][k])
				send(OP_SYMBOL, a, SEQ_W'($urandom), POS_W'(k),
					SYM_IN_W'($urandom_range(fill_sym_max)), SYM_IN_W'($urandom),
					VALUE_W'($urandom));
			if (!sym_ok[b][k])
				send(OP_SYMBOL, b, SEQ_W'($urandom), POS_W'(k),
					SYM_IN_W'($urandom_range(fill_sym_max)), SYM_IN_W'($urandom),
					VALUE_W'($urandom));
		end
		for (int k = 0; k < cols; k++) begin
			xa = tracker.sym[a][k];
			xb = tracker.sym[b][k];
			if (!tab_ok[xa][xb])
				send(OP_TABLE, SEQ_W'($urandom), SEQ_W'($urandom), POS_W'($urandom),
					xa, xb, VALUE_W'($urandom));
		end
		send(OP_SCORE, a, b, POS_W'($urandom), SYM_IN_W'($urandom), SYM_IN_W'($urandom),
			VALUE_W'($urandom));
	endtask

	function automatic logic [SEQ_W-1:0] pick_seq();
		if ($urandom_range(5) == 0)
			return SEQ_W'($urandom);
		return seq_pool[$urandom_range(3)];
	endfunction

	task automatic run_short(int n);
		int stop_at;
		stop_at = items + n;
		while (items < stop_at)
			if ($urandom_range(99) < 30)
				noise_write();
			else
				score_pair(pick_seq(), pick_seq());
	endtask

	// full-length pairs stay on two sequences so the fill stays affordable
	task automatic run_long(int n);
		repeat (n)
			if ($urandom_range(99) < 25)
				noise_write();
			else
				score_pair(($urandom_range(1) != 0) ? SEQ_W'(MAX_SEQS_DEF - 1) : '0,
					($urandom_range(1) != 0) ? SEQ_W'(MAX_SEQS_DEF - 1) : '0);
	endtask

	initial begin : stimulus
		tracker = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes of value, symbol, sequence and column on a two-column walk
		set_length(2);
		send(OP_TABLE, '0, '0, '0, 5'd0, 5'd0, -16'sd32768);
		send(OP_TABLE, '1, '1, '1, 5'd31, 5'd31, 16'sd32767);
		send(OP_TABLE, '0, '1, '0, 5'd0, 5'd31, 16'sh0100);
		send(OP_TABLE, '1, '0, '1, 5'd31, 5'd0, -16'sh0100);
		send(OP_WEIGHT, '0, '0, 8'd0, '0, '0, -16'sd32768);
		send(OP_WEIGHT, '1, '1, 8'd1, '1, '1, 16'sd32767);
		send(OP_WEIGHT, '1, '0, 8'd255, '1, '0, 16'sh5555);
		send(OP_SYMBOL, 6'd0, '1, 8'd0, 5'd0, '1, '0);
		send(OP_SYMBOL, 6'd0, '0, 8'd1, 5'd31, '0, '1);
		send(OP_SYMBOL, 6'd63, '1, 8'd0, 5'd31, '1, '0);
		send(OP_SYMBOL, 6'd63, '0, 8'd1, 5'd0, '0, '1);
		send(OP_SYMBOL, 6'd63, '1, 8'd255, 5'd31, '1, '1);
		score_pair(6'd0, 6'd63);
		score_pair(6'd63, 6'd0);
		score_pair(6'd0, 6'd0);
		score_pair(6'd63, 6'd63);

		for (int p = 0; p < 8; p++) begin
			set_length(CFG_W'(phase_len[p]));
			set_mode(phase_mode[p]);
			if (phase_len[p] >= MAX_LEN_DEF) begin
				fill_sym_max = 3;
				run_long(12);
			end else begin
				fill_sym_max = 31;
				seq_pool[0] = '0;
				seq_pool[1] = '1;
				seq_pool[2] = SEQ_W'($urandom);
				seq_pool[3] = SEQ_W'($urandom);
				if (p == 5) begin
					run_short(45);
					drain();
					run_short(45);
				end else
					run_short(90);
			end
		end
		drain();

		$display("%0d transactions sent and %0d scores compared", items, tracker.compared);
		$display("lengths 0 to 511 walked, with no idling, sender gaps, receiver stalls and both");
		if (tracker.errors == 0 && tracker.due_scores.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d scores never arrived", tracker.errors,
				tracker.due_scores.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#(10_000_000);
		$display("timeout with %0d scores outstanding", tracker.due_scores.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
